// File: rtl/mfc_pkg.sv
// Shared constants and the slot record layout for the flow cache.
// No dependencies; imported by microflow_cache_evict_on_collision.
package mfc_pkg;

	localparam int SLOTS      = 4096;
	localparam int IDX_W      = $clog2(SLOTS);
	localparam int LEN_W      = 13;
	localparam int KEY_W      = 96;
	localparam int KEY_BYTES  = 12;
	localparam int HASH_W     = 32;
	localparam int PKT_W      = 16;
	localparam int BYTE_W     = 32;
	localparam int HASH_MULT  = 101;
	localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(4096);
	localparam logic [LEN_W-1:0] LEN_MAX   = LEN_W'(SLOTS);

	typedef struct packed {
		logic [KEY_W-1:0]  key;
		logic [PKT_W-1:0]  packets;
		logic [BYTE_W-1:0] bytes;
	} slot_rec_t;

endpackage

// File: rtl/microflow_cache_evict_on_collision.sv
// Direct-mapped flow cache, evict on collision: top level.
// Depends on mfc_pkg for constants and the slot record type.
//
// One packet word at a time: an accepted word passes through the byte-serial
// hash, the bit-serial remainder by table_len, the slot memory read and the
// update, and the block then returns to idle to take the next word. After reset
// the block clears all 4096 slots, one per cycle, and accepts no packet word
// until the clear is done; table_len writes are taken at any time but belong
// between packets. An evicted record waits in an output register while the
// next packet word is taken; a further eviction holds the update, and with
// it the input, until that register is free.
module microflow_cache_evict_on_collision
	import mfc_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [LEN_W-1:0]      cfg_data,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [31:0]           src_addr,
	input  logic [31:0]           dst_addr,
	input  logic [15:0]           src_port,
	input  logic [15:0]           dst_port,
	input  logic [15:0]           packet_bytes,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [31:0]           ev_src_addr,
	output logic [31:0]           ev_dst_addr,
	output logic [15:0]           ev_src_port,
	output logic [15:0]           ev_dst_port,
	output logic [PKT_W-1:0]      ev_packets,
	output logic [BYTE_W-1:0]     ev_bytes
);

	typedef enum logic [2:0] {
		ST_CLEAR, ST_IDLE, ST_HASH, ST_MOD, ST_READ, ST_UPD
	} state_t;

	state_t            state_q;
	logic [LEN_W-1:0]  table_len_q;
	logic [IDX_W-1:0]  clr_q;
	logic [KEY_W-1:0]  key_q;
	logic [KEY_W-1:0]  sh_q;
	logic [15:0]       len_q;
	logic [HASH_W-1:0] h_q;
	logic [LEN_W-1:0]  rem_q;
	logic [4:0]        cnt_q;
	logic              out_valid_q;
	slot_rec_t         out_q;

	slot_rec_t         mem [SLOTS];
	slot_rec_t         rdata_q;
	logic              mem_we;
	logic              mem_re;
	logic [IDX_W-1:0]  mem_addr;
	slot_rec_t         mem_wdata;

	logic [LEN_W-1:0]  eff_len;
	logic [HASH_W-1:0] h_next;
	logic [LEN_W-1:0]  rem_sh;
	logic [LEN_W-1:0]  rem_next;
	logic              empty;
	logic              same;
	logic              evict;
	logic              out_free;
	logic              ev_take;

	assign cfg_ready = 1'b1;
	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;
	assign ev_src_addr = out_q.key[95:64];
	assign ev_dst_addr = out_q.key[63:32];
	assign ev_src_port = out_q.key[31:16];
	assign ev_dst_port = out_q.key[15:0];
	assign ev_packets  = out_q.packets;
	assign ev_bytes    = out_q.bytes;

	always_comb begin
		if (table_len_q == '0) begin
			eff_len = LEN_W'(1);
		end else if (table_len_q > LEN_MAX) begin
			eff_len = LEN_MAX;
		end else begin
			eff_len = table_len_q;
		end
	end

	assign h_next = HASH_W'(h_q * HASH_W'(HASH_MULT)) + HASH_W'(sh_q[KEY_W-1 -: 8]);
	assign rem_sh = {rem_q[LEN_W-2:0], h_q[HASH_W-1]};
	assign rem_next = (rem_sh >= eff_len) ? (rem_sh - eff_len) : rem_sh;

	assign empty    = (rdata_q.key == '0);
	assign same     = (rdata_q.key == key_q);
	assign evict    = !empty && !same;
	assign out_free = !out_valid_q || !out_stall;
	assign ev_take  = (state_q == ST_UPD) && evict && out_free;

	always_comb begin
		mem_we    = 1'b0;
		mem_re    = 1'b0;
		mem_addr  = rem_q[IDX_W-1:0];
		mem_wdata = '{key: key_q, packets: PKT_W'(1), bytes: BYTE_W'(len_q)};
		case (state_q)
			ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_addr  = clr_q;
				mem_wdata = '0;
			end
			ST_READ: begin
				mem_re = 1'b1;
			end
			ST_UPD: begin
				// hold the update while an eviction cannot be handed over
				mem_we = !evict || out_free;
				if (!empty && same) begin
					mem_wdata.packets = rdata_q.packets + PKT_W'(1);
					mem_wdata.bytes   = rdata_q.bytes + BYTE_W'(len_q);
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_addr] <= mem_wdata;
		end
		if (mem_re) begin
			rdata_q <= mem[mem_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			table_len_q <= LEN_RESET;
			clr_q       <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				table_len_q <= cfg_data;
			end
			if (ev_take) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + IDX_W'(1);
					if (clr_q == IDX_W'(SLOTS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_valid) begin
						key_q   <= {src_addr, dst_addr, src_port, dst_port};
						sh_q    <= {src_addr, dst_addr, src_port, dst_port};
						len_q   <= packet_bytes;
						h_q     <= '0;
						cnt_q   <= '0;
						state_q <= ST_HASH;
					end
				end
				ST_HASH: begin
					h_q   <= h_next;
					sh_q  <= {sh_q[KEY_W-9:0], 8'h00};
					if (cnt_q == 5'(KEY_BYTES - 1)) begin
						cnt_q   <= '0;
						rem_q   <= '0;
						state_q <= ST_MOD;
					end else begin
						cnt_q <= cnt_q + 5'd1;
					end
				end
				ST_MOD: begin
					// one quotient bit a cycle, MSB of the hash first
					rem_q <= rem_next;
					h_q   <= {h_q[HASH_W-2:0], 1'b0};
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'(HASH_W - 1)) begin
						state_q <= ST_READ;
					end
				end
				ST_READ: begin
					state_q <= ST_UPD;
				end
				ST_UPD: begin
					if (evict) begin
						if (out_free) begin
							out_q   <= rdata_q;
							state_q <= ST_IDLE;
						end
					end else begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule
